@@ src/pc2pi_pkg.sv @@
// Package for the pitch to phase increment converter: constants and table function.
package pc2pi_pkg;

  // pitch offset of A4 (6900 cents) in 1/65536 cent units
  localparam logic [32:0] PITCH_OFFSET = 33'd452198400;
  // bias that makes the octave numerator positive: 34 octaves of 75 units
  localparam logic [12:0] OCT_BIAS     = 13'd2550;
  localparam logic [6:0]  OCT_BIAS_K   = 7'd34;
  // octave is 75 * 2^20 units
  localparam logic [6:0]  OCT_DIV      = 7'd75;
  // reciprocal of 75 as ceil(2^36/75), exact for numerators below 2^32
  localparam logic [29:0] RECIP75      = 30'd916259690;
  localparam int          RECIP_SHIFT  = 36;
  localparam logic [8:0]  FREQ_MUL     = 9'd440;
  localparam logic [6:0]  SHIFT_BIAS   = 7'd6;
  localparam logic [17:0] RATE_RESET   = 18'd22050;
  localparam logic [63:0] LN2_Q32      = 64'd2977044472;
  localparam int          SERIES_TERMS = 20;

  // Q2.30 value of 2^(i / 2^tb), evaluated at elaboration only
  function automatic logic [31:0] pow2_entry(input int tb, input int i);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] prod;
    y    = (64'(i) * LN2_Q32 + (64'd1 << (tb - 1))) >> tb;
    term = 64'd1 << 32;
    sum  = term;
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      prod = (term * y) >> 32;
      term = prod / 64'(n);
      sum  = sum + term;
    end
    return 32'((sum + 64'd2) >> 2);
  endfunction

endpackage

@@ src/pc2pi_if.sv @@
// Channel interfaces of the pitch to phase increment converter.
interface pc2pi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pitch_cents;
  modport source (output valid, output pitch_cents, input ready);
  modport sink   (input valid, input pitch_cents, output ready);
endinterface

interface pc2pi_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] phase_increment;
  logic        saturated;
  modport source (output valid, output phase_increment, output saturated, input ready);
  modport sink   (input valid, input phase_increment, input saturated, output ready);
endinterface

interface pc2pi_cfg_if;
  logic        valid;
  logic        ready;
  logic [17:0] sample_rate;
  modport source (output valid, output sample_rate, input ready);
  modport sink   (input valid, input sample_rate, output ready);
endinterface

@@ src/pitch_cents_to_phase_increment.sv @@
// Pipelined absolute pitch (cents * 65536) to oscillator phase increment converter.
//
//  channel    dir  payload                           transfer
//  in_chan    in   pitch_cents  s32                   valid & ready
//  out_chan   out  phase_increment u32, saturated     valid & ready
//  cfg_chan   in   sample_rate  u18                   valid & ready (ready always high)
//
// 27 register stages: one item per cycle while the output is not stalled; the 32-bit
// quotient by sample_rate (2 bits per stage, 16 stages) sets the depth.
// rst_n (synchronous) empties the pipeline and loads sample_rate = 22050.
// Each stage moves when it is empty or its successor moves, so a stalled
// output holds its item while earlier bubbles still fill up.
module pitch_cents_to_phase_increment
  import pc2pi_pkg::*;
#(
  parameter int TABLE_BITS = 10
) (
  input  logic         clk,
  input  logic         rst_n,
  pc2pi_in_if.sink     in_chan,
  pc2pi_out_if.source  out_chan,
  pc2pi_cfg_if.sink    cfg_chan
);

  localparam int TBL_N   = (1 << TABLE_BITS) + 1;
  localparam int YW      = TABLE_BITS + 7;
  localparam int DIV_STG = 16;
  localparam int ST_OFS  = 0;
  localparam int ST_K    = 1;
  localparam int ST_F    = 2;
  localparam int ST_IDX  = 3;
  localparam int ST_TBL  = 4;
  localparam int ST_MUL  = 5;
  localparam int ST_Z    = 6;
  localparam int ST_FRAC = 7;
  localparam int ST_NUM  = 8;
  localparam int ST_SHF  = 9;
  localparam int ST_DIV0 = 10;
  localparam int NST     = ST_DIV0 + DIV_STG + 1;

  // configuration register
  logic [17:0] rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RESET;
    end else if (cfg_chan.valid) begin
      rate_r <= cfg_chan.sample_rate;
    end
  end

  assign cfg_chan.ready = 1'b1;

  // stage valid bits and enables
  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_chan.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_chan.valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  assign in_chan.ready = en[0];

  // power-of-two table, constant ROM
  logic [31:0] rom [TBL_N];

  for (genvar g = 0; g < TBL_N; g++) begin : g_rom
    assign rom[g] = pow2_entry(TABLE_BITS, g);
  end

  // stage 0: offset and split off the low 20 bits
  logic [32:0] d_c;
  logic [12:0] x_r;
  logic [19:0] lo_r;
  assign d_c = {in_chan.pitch_cents[31], in_chan.pitch_cents} - PITCH_OFFSET;

  // stage 1: octave quotient by reciprocal
  logic [42:0] kp_c;
  logic [5:0]  q1_r;
  logic [12:0] x1_r;
  logic [19:0] lo1_r;
  assign kp_c = x_r * RECIP75;

  // stage 2: octave number and fraction
  logic [6:0]  rem_c;
  logic [26:0] f_c;
  logic [6:0]  k2_r;
  logic [YW-1:0] y2_r;
  logic [19:0] pl2_r;
  assign rem_c = 7'(x1_r - 13'(q1_r) * 13'(OCT_DIV));
  assign f_c   = {rem_c, lo1_r};

  // stage 3: table index by reciprocal
  logic [YW+29:0] ip_c;
  logic [TABLE_BITS-1:0] idx3_r;
  logic [6:0]  k3_r;
  logic [YW-1:0] y3_r;
  logic [19:0] pl3_r;
  assign ip_c = y2_r * RECIP75;

  // stage 4: table read and interpolation position
  logic [TABLE_BITS:0] ia_c;
  logic [31:0] t0_4_r;
  logic [31:0] t1_4_r;
  logic [6:0]  a4_r;
  logic [19:0] b4_r;
  logic [6:0]  k4_r;
  assign ia_c = {1'b0, idx3_r};

  // stage 5: partial products of slope times position
  logic [31:0] dt_c;
  logic [38:0] pa5_r;
  logic [51:0] pb5_r;
  logic [31:0] t0_5_r;
  logic [6:0]  k5_r;
  assign dt_c = t1_4_r - t0_4_r;

  // stage 6: slope times position over 2^20
  logic [31:0] z6_r;
  logic [31:0] t0_6_r;
  logic [6:0]  k6_r;

  // stage 7: divide by 75
  logic [61:0] zp_c;
  logic [25:0] fq7_r;
  logic [31:0] t0_7_r;
  logic [6:0]  k7_r;
  assign zp_c = z6_r * RECIP75;

  // stage 8: mantissa times 440
  logic [31:0] m_c;
  logic [40:0] np_c;
  logic [39:0] num8_r;
  logic [6:0]  k8_r;
  assign m_c  = t0_7_r + 32'(fq7_r);
  assign np_c = m_c * FREQ_MUL;

  // stage 9: scale by 2^(k-6)
  logic [6:0]  s_c;
  logic [54:0] nw_c;
  logic [54:0] ns_c;
  logic [22:0] nhi9_r;
  logic [31:0] nlo9_r;
  assign s_c  = k8_r - SHIFT_BIAS;
  assign nw_c = {15'd0, num8_r};
  assign ns_c = s_c[6] ? (nw_c >> 6'(-s_c)) : (nw_c << s_c[5:0]);

  // stage 10 onward: overflow check and restoring division
  logic [17:0] dr_r [DIV_STG+1];
  logic [31:0] dw_r [DIV_STG+1];
  logic        ds_r [DIV_STG+1];

  always_ff @(posedge clk) begin
    if (en[ST_OFS]) begin
      x_r  <= d_c[32:20] + OCT_BIAS;
      lo_r <= d_c[19:0];
    end
    if (en[ST_K]) begin
      q1_r  <= kp_c[41:36];
      x1_r  <= x_r;
      lo1_r <= lo_r;
    end
    if (en[ST_F]) begin
      k2_r  <= 7'(q1_r) - OCT_BIAS_K;
      y2_r  <= f_c[26:20-TABLE_BITS];
      pl2_r <= {f_c[19-TABLE_BITS:0], TABLE_BITS'(0)};
    end
    if (en[ST_IDX]) begin
      idx3_r <= ip_c[RECIP_SHIFT +: TABLE_BITS];
      k3_r   <= k2_r;
      y3_r   <= y2_r;
      pl3_r  <= pl2_r;
    end
    if (en[ST_TBL]) begin
      t0_4_r <= rom[ia_c];
      t1_4_r <= rom[ia_c + 1'b1];
      a4_r   <= 7'(y3_r - YW'(idx3_r) * YW'(OCT_DIV));
      b4_r   <= pl3_r;
      k4_r   <= k3_r;
    end
    if (en[ST_MUL]) begin
      pa5_r  <= dt_c * a4_r;
      pb5_r  <= dt_c * b4_r;
      t0_5_r <= t0_4_r;
      k5_r   <= k4_r;
    end
    if (en[ST_Z]) begin
      z6_r   <= 32'(pa5_r + 39'(pb5_r[51:20]));
      t0_6_r <= t0_5_r;
      k6_r   <= k5_r;
    end
    if (en[ST_FRAC]) begin
      fq7_r  <= zp_c[61:36];
      t0_7_r <= t0_6_r;
      k7_r   <= k6_r;
    end
    if (en[ST_NUM]) begin
      num8_r <= np_c[39:0];
      k8_r   <= k7_r;
    end
    if (en[ST_SHF]) begin
      nhi9_r <= ns_c[54:32];
      nlo9_r <= ns_c[31:0];
    end
    if (en[ST_DIV0]) begin
      ds_r[0] <= (nhi9_r >= {5'd0, rate_r});
      dr_r[0] <= nhi9_r[17:0];
      dw_r[0] <= nlo9_r;
    end
  end

  // two quotient bits per stage
  for (genvar j = 0; j < DIV_STG; j++) begin : g_div
    logic [18:0] r1_c;
    logic [17:0] ra_c;
    logic        qa_c;
    logic [18:0] r2_c;
    logic [17:0] rb_c;
    logic        qb_c;

    always_comb begin
      r1_c = {dr_r[j], dw_r[j][31]};
      qa_c = (r1_c >= {1'b0, rate_r});
      ra_c = qa_c ? 18'(r1_c - {1'b0, rate_r}) : r1_c[17:0];
      r2_c = {ra_c, dw_r[j][30]};
      qb_c = (r2_c >= {1'b0, rate_r});
      rb_c = qb_c ? 18'(r2_c - {1'b0, rate_r}) : r2_c[17:0];
    end

    always_ff @(posedge clk) begin
      if (en[ST_DIV0+1+j]) begin
        dr_r[j+1] <= rb_c;
        dw_r[j+1] <= {dw_r[j][29:0], qa_c, qb_c};
        ds_r[j+1] <= ds_r[j];
      end
    end
  end

  // output
  assign out_chan.valid           = v_r[NST-1];
  assign out_chan.saturated       = ds_r[DIV_STG];
  assign out_chan.phase_increment = ds_r[DIV_STG] ? '1 : dw_r[DIV_STG];

  // a clamped result always reads as all ones
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.saturated |-> out_chan.phase_increment == 32'hFFFF_FFFF)
    else $error("saturated result not clamped");

  // a zero divisor always takes the saturation path
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(v_r[ST_SHF] && en[ST_DIV0] && rate_r == 18'd0) && rate_r == 18'd0
      |-> ds_r[0])
    else $error("zero sample rate not saturated");

  // the pipeline is empty right after reset
  assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("result valid after reset");

  // an accepted item shows up as valid in the first stage
  assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> v_r[ST_OFS])
    else $error("accepted item lost in first stage");

endmodule

@@ tb/pitch_cents_to_phase_increment_test.sv @@
// Testbench for the pitch to phase increment converter: random and directed pitches vs. predictor.
`timescale 1ns / 1ps

module pitch_cents_to_phase_increment_test;
  import pc2pi_pkg::*;

  localparam int      FRAC_BITS    = 10;
  localparam longint  A4_OFFSET    = 64'sd452198400;
  localparam longint  OCTAVE_SPAN  = 64'sd78643200;
  localparam int      PIPE_DEPTH   = 27;
  localparam int      CYCLE_LIMIT  = 400000;
  localparam int      RANDOM_ITEMS = 900;

  typedef struct {
    logic [31:0] inc;
    logic        sat;
  } step_result_t;

  typedef struct {
    logic signed [31:0] pitch;
    bit                 known;
    logic [31:0]        inc;
    logic               sat;
  } pitch_row_t;

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   error_count;

  pc2pi_in_if  in_chan();
  pc2pi_out_if out_chan();
  pc2pi_cfg_if cfg_chan();

  pitch_cents_to_phase_increment #(.TABLE_BITS(FRAC_BITS)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Q2.30 table of 2^(i/1024), built by the series sum
  longint unsigned exp2_table [0:(1 << FRAC_BITS)];
  logic [17:0]     rate_shadow;
  step_result_t    pending_increments [$];

  function automatic longint unsigned exp2_q230(input longint unsigned i);
    longint unsigned y;
    longint unsigned term;
    longint unsigned acc;
    y    = (i * 64'd2977044472 + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    term = 64'd1 << 32;
    acc  = term;
    for (int n = 1; n <= 20; n++) begin
      term = ((term * y) >> 32) / longint'(n);
      acc  = acc + term;
    end
    return (acc + 64'd2) >> 2;
  endfunction

  // Octave split, interpolation, scaling and clamp
  function automatic step_result_t phase_step(input logic signed [31:0] pitch,
                                              input logic [17:0] rate);
    longint          d;
    longint          k;
    longint          r;
    longint          s;
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned rem;
    longint unsigned t0;
    longint unsigned t1;
    longint unsigned m;
    longint unsigned num;
    longint unsigned q;
    step_result_t    res;
    d = longint'(pitch) - A4_OFFSET;
    k = d / OCTAVE_SPAN;
    r = d % OCTAVE_SPAN;
    if (r < 0) begin
      r = r + OCTAVE_SPAN;
      k = k - 1;
    end
    pos = longint'(r) << FRAC_BITS;
    idx = pos / OCTAVE_SPAN;
    rem = pos % OCTAVE_SPAN;
    t0  = exp2_table[idx];
    t1  = exp2_table[idx + 1];
    m   = t0 + ((t1 - t0) * rem) / OCTAVE_SPAN;
    if (rate == 0) begin
      res.inc = 32'hFFFF_FFFF;
      res.sat = 1'b1;
      return res;
    end
    num = m * 440;
    s   = k - 6;
    if (s >= 0) q = (num << s) / longint'(rate);
    else if (-s > 45) q = 0;
    else q = num / (longint'(rate) << (-s));
    if (q > 64'hFFFF_FFFF) begin
      res.inc = 32'hFFFF_FFFF;
      res.sat = 1'b1;
    end else begin
      res.inc = q[31:0];
      res.sat = 1'b0;
    end
    return res;
  endfunction

  // Clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[pitch_cents_to_phase_increment] ERROR");
      $finish;
    end
  end

  // Check each output transfer against the oldest pending result
  always @(posedge clk) begin
    step_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_increments.size() == 0) begin
        $error("unexpected result: phase_increment %0d saturated %0d",
               out_chan.phase_increment, out_chan.saturated);
        error_count++;
      end else begin
        want = pending_increments.pop_front();
        if (out_chan.phase_increment !== want.inc) begin
          $error("phase_increment: expected %0d, actual %0d", want.inc,
                 out_chan.phase_increment);
          error_count++;
        end
        if (out_chan.saturated !== want.sat) begin
          $error("saturated: expected %0d, actual %0d", want.sat, out_chan.saturated);
          error_count++;
        end
      end
    end
  end

  // Receiver stalls: rotating pattern, reloaded now and then, sometimes all-open
  logic [7:0] stall_pattern;
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pattern <= 8'hFF;
        1: stall_pattern <= 8'($urandom) | 8'h01;
        2: stall_pattern <= 8'h11;
        default: stall_pattern <= 8'($urandom);
      endcase
    end else begin
      stall_pattern <= {stall_pattern[6:0], stall_pattern[7]};
    end
    out_chan.ready <= stall_pattern[0];
  end

  int burst_left;

  // Send one pitch; burst/gap shaping happens ahead of the transfer
  task automatic send_pitch(input logic signed [31:0] pitch, input bit known,
                            input logic [31:0] inc, input logic sat);
    step_result_t want;
    if (burst_left == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 6);
    end
    burst_left--;
    in_chan.valid       <= 1'b1;
    in_chan.pitch_cents <= pitch;
    do @(posedge clk); while (!in_chan.ready);
    if (known) begin
      want.inc = inc;
      want.sat = sat;
    end else begin
      want = phase_step(pitch, rate_shadow);
    end
    pending_increments.push_back(want);
    @(negedge clk);
  endtask

  // Hold input low until every pending result has arrived
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (pending_increments.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 4) @(negedge clk);
  endtask

  task automatic write_rate(input logic [17:0] rate);
    drain_results();
    cfg_chan.valid       <= 1'b1;
    cfg_chan.sample_rate <= rate;
    do @(posedge clk); while (!cfg_chan.ready);
    rate_shadow = rate;
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] random_pitch();
    case ($urandom_range(0, 7))
      0: return 32'(A4_OFFSET) + $signed($urandom_range(0, 200000000)) - 100000000;
      1: return 32'sd1300000000 + $signed($urandom_range(0, 600000000));
      2: return -32'sd2147483648 + $signed($urandom_range(0, 1000));
      3: return 32'(A4_OFFSET + OCTAVE_SPAN * ($signed($urandom_range(0, 40)) - 20))
                + $signed($urandom_range(0, 4)) - 2;
      default: return $urandom;
    endcase
  endfunction

  pitch_row_t directed_rows [] = '{
    '{32'sd452198400,  1'b1, 32'd334783,      1'b0},
    '{-32'sd2147483648, 1'b1, 32'd0,          1'b0},
    '{32'sd2147483647, 1'b1, 32'hFFFF_FFFF,   1'b1},
    '{32'sd0,          1'b0, 32'd0,           1'b0},
    '{-32'sd1,         1'b0, 32'd0,           1'b0},
    '{32'sd1,          1'b0, 32'd0,           1'b0},
    '{32'sd452198399,  1'b0, 32'd0,           1'b0},
    '{32'sd452198401,  1'b0, 32'd0,           1'b0},
    '{32'sd530841600,  1'b0, 32'd0,           1'b0},
    '{32'sd373555200,  1'b0, 32'd0,           1'b0},
    '{32'sd530841599,  1'b0, 32'd0,           1'b0},
    '{32'sh5555_5555,  1'b0, 32'd0,           1'b0},
    '{32'shAAAA_AAAA,  1'b0, 32'd0,           1'b0},
    '{32'sd1400000000, 1'b0, 32'd0,           1'b0},
    '{32'sd1500000000, 1'b0, 32'd0,           1'b0},
    '{32'sd1600000000, 1'b0, 32'd0,           1'b0},
    '{32'sd452275200,  1'b0, 32'd0,           1'b0},
    '{32'sd452198400 + 32'sd76800, 1'b0, 32'd0, 1'b0},
    '{-32'sd1000000000, 1'b0, 32'd0,          1'b0}
  };

  logic [17:0] rate_plan [] = '{18'd1, 18'd200000, 18'd262143, 18'd0, 18'd48000,
                                18'd44100, 18'd3, 18'd22050};

  initial begin
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.pitch_cents  = '0;
    out_chan.ready       = 1'b0;
    cfg_chan.valid       = 1'b0;
    cfg_chan.sample_rate = '0;
    stall_pattern        = 8'hFF;
    cycle_count          = 0;
    error_count          = 0;
    burst_left           = 0;
    rate_shadow          = RATE_RESET;
    for (int i = 0; i <= (1 << FRAC_BITS); i++) exp2_table[i] = exp2_q230(i);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows at the reset sample rate
    foreach (directed_rows[i])
      send_pitch(directed_rows[i].pitch, directed_rows[i].known,
                 directed_rows[i].inc, directed_rows[i].sat);

    // Random pitches over a series of sample rates, one with a random value
    for (int ph = 0; ph <= rate_plan.size(); ph++) begin
      if (ph == rate_plan.size()) write_rate(18'($urandom_range(1, 200000)));
      else write_rate(rate_plan[ph]);
      for (int n = 0; n < RANDOM_ITEMS / (rate_plan.size() + 1); n++) begin
        if (n == 40) drain_results();
        send_pitch(random_pitch(), 1'b0, 32'd0, 1'b0);
      end
    end

    in_chan.valid <= 1'b0;
    while (pending_increments.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 10) @(negedge clk);
    if (error_count == 0) begin
      $display("[pitch_cents_to_phase_increment] OK");
    end else begin
      $display("[pitch_cents_to_phase_increment] ERROR");
    end
    $finish;
  end

endmodule
